FILE: rtl/core/first_fit_range_allocator_core_defines.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_CORE_DEFINES_SVH

// invariant checked at every rising clock edge outside reset
`define FFRA_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("invariant violated");

// antecedent in one cycle implies consequent in the next
`define FFRA_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
		else $error("sequence violated");

`endif

FILE: rtl/core/ffra_pkg.sv
// Types, codes and helpers for the first-fit range allocator.
// No dependencies; used by ffra_cell and the core top level.
package ffra_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int ADDR_BITS   = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int SIZE_W      = ADDR_BITS + 1;

	localparam logic [SIZE_W-1:0] POOL_LIM = SIZE_W'(1) << ADDR_BITS;
	localparam logic [SIZE_W-1:0] POOL_RST = 17'd65536;

	// request kinds
	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_REALLOC = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOSPACE = 2'd1;
	localparam logic [1:0] STAT_BADOFF  = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] offset;
		logic [16:0] req_size;
	} ffra_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] block_start;
		logic [16:0] units_in_use;
	} ffra_rsp_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] lo;
		logic [ADDR_BITS-1:0] hi;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic fit;
		logic inpl;
	} flags_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_SET_HI
	} cell_op_t;

	typedef struct packed {
		cell_op_t             op;
		logic [IDX_W-1:0]     idx;
		logic [ADDR_BITS-1:0] lo;
		logic [ADDR_BITS-1:0] hi;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EVAL,
		FSM_DECIDE,
		FSM_DONE
	} fsm_t;

	// lowest set bit position of a flag row
	function automatic logic [IDX_W-1:0] ffra_first(input logic [MAX_ENTRIES-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/ffra_cell.sv
// One table cell: holds one sorted range entry and evaluates it locally.
// Depends on ffra_pkg; shifts with its neighbors on insert and remove.
module ffra_cell (
	input  logic                          clk,
	input  logic [ffra_pkg::IDX_W-1:0]    cell_index,
	input  logic [ffra_pkg::CNT_W-1:0]    count,
	input  logic [ffra_pkg::SIZE_W-1:0]   len,
	input  logic [15:0]                   pos,
	input  logic [ffra_pkg::SIZE_W-1:0]   size,
	input  ffra_pkg::entry_t              prev_e,
	input  ffra_pkg::entry_t              next_e,
	input  ffra_pkg::cell_cmd_t           cmd,
	output ffra_pkg::entry_t              e,
	output ffra_pkg::flags_t              flags
);
	import ffra_pkg::*;

	entry_t             e_q;
	logic               valid;
	logic               next_valid;
	logic [SIZE_W-1:0]  lim;
	logic [SIZE_W:0]    tail;
	logic [SIZE_W:0]    grow;
	logic [SIZE_W-1:0]  cur;

	assign e = e_q;

	// occupancy of this cell and its right neighbor
	assign valid      = {1'b0, cell_index} < count;
	assign next_valid = ({1'b0, cell_index} + CNT_W'(1)) < count;

	// room limit after this entry: next start or pool end
	assign lim  = next_valid ? {1'b0, next_e.lo} : len;
	assign tail = {2'b0, e_q.hi} + (SIZE_W + 1)'(1) + {1'b0, size};
	assign grow = {2'b0, e_q.lo} + {1'b0, size};
	assign cur  = {1'b0, e_q.hi} - {1'b0, e_q.lo} + SIZE_W'(1);

	// local flags
	always_comb begin
		flags.hit  = valid && ({1'b0, e_q.lo} <= {1'b0, pos}) && (pos <= e_q.hi);
		flags.fit  = valid && (tail <= {1'b0, lim}) && (tail <= {1'b0, len});
		flags.inpl = valid && ((size <= cur) || (grow <= {1'b0, lim}));
	end

	// entry storage, shifting with neighbors
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_INSERT: begin
				if (cell_index == cmd.idx) begin
					e_q.lo <= cmd.lo;
					e_q.hi <= cmd.hi;
				end else if (cell_index > cmd.idx) begin
					e_q <= prev_e;
				end
			end
			CELL_REMOVE: begin
				if (cell_index >= cmd.idx) e_q <= next_e;
			end
			CELL_SET_HI: begin
				if (cell_index == cmd.idx) e_q.hi <= cmd.hi;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/first_fit_range_allocator_core.sv
// Top level of the first-fit range allocator: request sequencer, pool
// register and a row of ffra_cell entries. Depends on ffra_pkg and the defines header.
//
// channel  dir  handshake             payload
// in       in   in_valid / in_stall    in_data  (ffra_req_t)
// out      out  out_valid / out_stall  out_data (ffra_rsp_t)
// cfg      in   cfg_valid / cfg_ready  cfg_data (pool_size, 17 bits)
//
// One request at a time: accept, an evaluate state in which every cell
// checks its own entry, a decide state that shifts the row, a done state
// that loads the output register. A realloc that moves its block passes
// evaluate and decide twice; done waits while out_stall holds the output.
// in_stall stays high until the result is loaded into the output register;
// out_stall holds it there. Reset empties the table, clears usage and sets
// the pool to 65536 units; cells need none.
`include "first_fit_range_allocator_core_defines.svh"
module first_fit_range_allocator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ffra_pkg::ffra_req_t in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ffra_pkg::ffra_rsp_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [16:0]         cfg_data
);
	import ffra_pkg::*;

	fsm_t               state_q, state_d;
	ffra_req_t          req_q;
	logic               phase_q;
	logic [CNT_W-1:0]   count_q;
	logic [SIZE_W-1:0]  used_q;
	logic [SIZE_W-1:0]  pool_q;
	logic [SIZE_W-1:0]  len;
	logic               out_valid_q;
	ffra_rsp_t          rsp_q;
	logic [1:0]         res_status_q;
	logic [15:0]        res_start_q;

	entry_t             ent [MAX_ENTRIES];
	flags_t             flg [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] hit_q, fit_q, inpl_q;
	logic               front_q;
	logic               size_ok_q;
	cell_cmd_t          cmd;

	logic               accept;
	logic               out_free;
	logic               hit_any, fit_any;
	logic [IDX_W-1:0]   hit_idx, fit_idx, sel_idx;
	entry_t             sel;
	logic [SIZE_W-1:0]  cur;
	logic [SIZE_W-1:0]  where_fit;
	logic               pos_ok;

	// decision of the decide cycle
	cell_cmd_t          dec_cmd;
	logic [1:0]         dec_status;
	logic [15:0]        dec_start;
	logic               dec_requeue;
	logic [SIZE_W-1:0]  dec_used;
	logic [CNT_W-1:0]   dec_count;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != FSM_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign len       = pool_q[SIZE_W-1] ? POOL_LIM : pool_q;

	// row of cells
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		entry_t pe, ne;
		if (g == 0) begin : g_first
			assign pe = '0;
		end else begin : g_mid
			assign pe = ent[g-1];
		end
		if (g == MAX_ENTRIES - 1) begin : g_last
			assign ne = '0;
		end else begin : g_inner
			assign ne = ent[g+1];
		end
		ffra_cell u_cell (
			.clk        (clk),
			.cell_index (IDX_W'(g)),
			.count      (count_q),
			.len        (len),
			.pos        (req_q.offset),
			.size       (req_q.req_size),
			.prev_e     (pe),
			.next_e     (ne),
			.cmd        (cmd),
			.e          (ent[g]),
			.flags      (flg[g])
		);
	end

	// flag capture from the evaluate cycle
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_q[i]  <= flg[i].hit;
			fit_q[i]  <= flg[i].fit;
			inpl_q[i] <= flg[i].inpl;
		end
		front_q   <= (count_q == '0) || (req_q.req_size <= {1'b0, ent[0].lo});
		size_ok_q <= req_q.req_size <= len;
	end

	// selection of the entry that the decision works on
	assign hit_any   = |hit_q;
	assign fit_any   = |fit_q;
	assign hit_idx   = ffra_first(hit_q);
	assign fit_idx   = ffra_first(fit_q);
	assign sel_idx   = (req_q.kind != KIND_ALLOC && !phase_q) ? hit_idx : fit_idx;
	assign sel       = ent[sel_idx];
	assign cur       = {1'b0, sel.hi} - {1'b0, sel.lo} + SIZE_W'(1);
	assign where_fit = {1'b0, sel.hi} + SIZE_W'(1);
	assign pos_ok    = {1'b0, req_q.offset} < len;

	// decision logic
	always_comb begin
		logic [SIZE_W:0]  need;
		logic [SIZE_W-1:0] ins_end;
		need        = {1'b0, req_q.req_size} + {1'b0, used_q};
		ins_end     = where_fit + req_q.req_size - SIZE_W'(1);
		dec_cmd     = '{op: CELL_HOLD, idx: '0, lo: '0, hi: '0};
		dec_status  = STAT_OK;
		dec_start   = '0;
		dec_requeue = 1'b0;
		dec_used    = used_q;
		dec_count   = count_q;
		if (phase_q) begin
			// second pass of a moving realloc: place in the reduced table
			dec_cmd.op = CELL_INSERT;
			dec_used   = used_q + req_q.req_size;
			dec_count  = count_q + CNT_W'(1);
			if (front_q) begin
				dec_cmd.idx = '0;
				dec_cmd.lo  = '0;
				dec_cmd.hi  = req_q.req_size[ADDR_BITS-1:0] - ADDR_BITS'(1);
				dec_start   = '0;
			end else begin
				dec_cmd.idx = IDX_W'({1'b0, fit_idx} + (IDX_W + 1)'(1));
				dec_cmd.lo  = where_fit[ADDR_BITS-1:0];
				dec_cmd.hi  = ins_end[ADDR_BITS-1:0];
				dec_start   = where_fit[15:0];
			end
		end else begin
			unique case (req_q.kind)
				KIND_ALLOC: begin
					if (req_q.req_size == '0 || need > {1'b0, len}) begin
						dec_status = STAT_NOSPACE;
					end else if (count_q == CNT_W'(MAX_ENTRIES)) begin
						dec_status = STAT_FULL;
					end else if (front_q) begin
						dec_cmd.op  = CELL_INSERT;
						dec_cmd.idx = '0;
						dec_cmd.lo  = '0;
						dec_cmd.hi  = req_q.req_size[ADDR_BITS-1:0] - ADDR_BITS'(1);
						dec_used    = used_q + req_q.req_size;
						dec_count   = count_q + CNT_W'(1);
					end else if (fit_any) begin
						dec_cmd.op  = CELL_INSERT;
						dec_cmd.idx = IDX_W'({1'b0, fit_idx} + (IDX_W + 1)'(1));
						dec_cmd.lo  = where_fit[ADDR_BITS-1:0];
						dec_cmd.hi  = ins_end[ADDR_BITS-1:0];
						dec_start   = where_fit[15:0];
						dec_used    = used_q + req_q.req_size;
						dec_count   = count_q + CNT_W'(1);
					end else begin
						dec_status = STAT_NOSPACE;
					end
				end
				KIND_FREE: begin
					if (!pos_ok || !hit_any) begin
						dec_status = STAT_BADOFF;
					end else begin
						dec_cmd.op  = CELL_REMOVE;
						dec_cmd.idx = hit_idx;
						dec_start   = sel.lo;
						dec_used    = used_q - cur;
						dec_count   = count_q - CNT_W'(1);
					end
				end
				KIND_REALLOC: begin
					if (!pos_ok || !hit_any) begin
						dec_status = STAT_BADOFF;
					end else if (req_q.req_size == '0) begin
						dec_status = STAT_NOSPACE;
					end else if (inpl_q[hit_idx]) begin
						// resize in place
						dec_cmd.op  = CELL_SET_HI;
						dec_cmd.idx = hit_idx;
						dec_cmd.hi  = sel.lo + req_q.req_size[ADDR_BITS-1:0] - ADDR_BITS'(1);
						dec_start   = sel.lo;
						dec_used    = used_q - cur + req_q.req_size;
					end else if (!(size_ok_q && (front_q || fit_any))) begin
						dec_status = STAT_NOSPACE;
					end else begin
						// drop the block, then search again
						dec_cmd.op  = CELL_REMOVE;
						dec_cmd.idx = hit_idx;
						dec_used    = used_q - cur;
						dec_count   = count_q - CNT_W'(1);
						dec_requeue = 1'b1;
					end
				end
				default: begin
					dec_status = STAT_BADOFF;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE:   if (accept) state_d = FSM_EVAL;
			FSM_EVAL:   state_d = FSM_DECIDE;
			FSM_DECIDE: state_d = dec_requeue ? FSM_EVAL : FSM_DONE;
			FSM_DONE:   if (out_free) state_d = FSM_IDLE;
			default:    state_d = FSM_IDLE;
		endcase
	end

	// cell command
	always_comb begin
		cmd = '{op: CELL_HOLD, idx: '0, lo: '0, hi: '0};
		if (state_q == FSM_DECIDE) cmd = dec_cmd;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			phase_q     <= 1'b0;
			count_q     <= '0;
			used_q      <= '0;
			pool_q      <= POOL_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) pool_q <= cfg_data;
			if (accept) phase_q <= 1'b0;
			if (state_q == FSM_DECIDE) begin
				phase_q <= dec_requeue;
				count_q <= dec_count;
				used_q  <= dec_used;
			end
			if (state_q == FSM_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) req_q <= in_data;
		if (state_q == FSM_DECIDE && !dec_requeue) begin
			res_status_q <= dec_status;
			res_start_q  <= (dec_status == STAT_OK) ? dec_start : 16'd0;
		end
		if (state_q == FSM_DONE && out_free) begin
			rsp_q.status       <= res_status_q;
			rsp_q.block_start  <= res_start_q;
			rsp_q.units_in_use <= used_q;
		end
	end

	`FFRA_ASSERT_ALWAYS(a_count_max, clk, arst_n, count_q <= CNT_W'(MAX_ENTRIES))
	`FFRA_ASSERT_NEXT(a_accept_eval, clk, arst_n, accept, state_q == FSM_EVAL)
	`FFRA_ASSERT_NEXT(a_done_loads, clk, arst_n, state_q == FSM_DONE && out_free, out_valid)
	`FFRA_ASSERT_ALWAYS(a_phase_decide, clk, arst_n, !(phase_q && state_q == FSM_DECIDE) || (count_q < CNT_W'(MAX_ENTRIES)))

endmodule

FILE: test/first_fit_range_allocator_core_test.sv
// Self-checking testbench for first_fit_range_allocator_core: directed and random requests,
// pool size changes between phases, random gaps on both channels. Depends on ffra_pkg and the RTL.
`timescale 1ns / 100ps
module first_fit_range_allocator_core_test;
	import ffra_pkg::*;

	localparam logic [1:0] KIND_UNDEF = 2'd3;

	// Tracks the range table and holds expected responses in order
	class alloc_scoreboard;
		logic [16:0] pool;
		int lo[MAX_ENTRIES];
		int hi[MAX_ENTRIES];
		int count;
		int used;
		int errors;
		int checked;
		ffra_rsp_t expected_q[$];

		function new();
			pool = POOL_RST;
			count = 0;
			used = 0;
			errors = 0;
			checked = 0;
		endfunction

		function int pool_len();
			return (pool > POOL_LIM) ? int'(POOL_LIM) : int'(pool);
		endfunction

		// first-fit placement in the current table: insert index or -1
		function int fit(int size, output int where);
			int len;
			int s;
			len = pool_len();
			where = 0;
			if (size > len) return -1;
			if (count == 0 || size <= lo[0]) return 0;
			for (int i = 0; i + 1 < count; i++) begin
				s = hi[i] + 1;
				if (lo[i + 1] - s >= size && s + size <= len) begin
					where = s;
					return i + 1;
				end
			end
			s = hi[count - 1] + 1;
			if (len - s >= size) begin
				where = s;
				return count;
			end
			return -1;
		endfunction

		function void add_range(int idx, int s, int size);
			for (int i = count; i > idx; i--) begin
				lo[i] = lo[i - 1];
				hi[i] = hi[i - 1];
			end
			lo[idx] = s;
			hi[idx] = s + size - 1;
			count++;
			used += size;
		endfunction

		function void drop_range(int idx);
			used -= hi[idx] - lo[idx] + 1;
			for (int i = idx; i + 1 < count; i++) begin
				lo[i] = lo[i + 1];
				hi[i] = hi[i + 1];
			end
			count--;
		endfunction

		function int owner(int pos);
			if (pos >= pool_len()) return -1;
			for (int i = 0; i < count; i++)
				if (lo[i] <= pos && pos <= hi[i]) return i;
			return -1;
		endfunction

		// predict the response to one accepted request
		function void note_request(ffra_req_t r);
			ffra_rsp_t e;
			int size;
			int pos;
			int idx;
			int where;
			int s;
			int cur;
			logic [1:0] st;
			int start;
			size = r.req_size;
			pos = r.offset;
			st = STAT_OK;
			start = 0;
			case (r.kind)
				KIND_ALLOC: begin
					if (size == 0 || size > pool_len() - used) st = STAT_NOSPACE;
					else if (count >= MAX_ENTRIES) st = STAT_FULL;
					else begin
						idx = fit(size, where);
						if (idx < 0) st = STAT_NOSPACE;
						else begin
							add_range(idx, where, size);
							start = where;
						end
					end
				end
				KIND_FREE: begin
					idx = owner(pos);
					if (idx < 0) st = STAT_BADOFF;
					else begin
						start = lo[idx];
						drop_range(idx);
					end
				end
				KIND_REALLOC: begin
					idx = owner(pos);
					if (idx < 0) st = STAT_BADOFF;
					else if (size == 0) st = STAT_NOSPACE;
					else begin
						s = lo[idx];
						cur = hi[idx] - s + 1;
						if (size <= cur || (idx + 1 != count && lo[idx + 1] - s >= size) ||
								(idx + 1 == count && pool_len() - s >= size)) begin
							used = used - cur + size;
							hi[idx] = s + size - 1;
							start = s;
						end else if (fit(size, where) < 0) st = STAT_NOSPACE;
						else begin
							drop_range(idx);
							idx = fit(size, where);
							add_range(idx, where, size);
							start = where;
						end
					end
				end
				default: st = STAT_BADOFF;
			endcase
			e.status = st;
			e.block_start = (st == STAT_OK) ? start[15:0] : 16'd0;
			e.units_in_use = used[16:0];
			expected_q.push_back(e);
		endfunction

		function void check_response(ffra_rsp_t a);
			ffra_rsp_t e;
			checked++;
			if (expected_q.size() == 0) begin
				$error("response with nothing expected: %p", a);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (a.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, a.status);
				errors++;
			end
			if (a.block_start !== e.block_start) begin
				$error("block_start: expected %0d, actual %0d", e.block_start, a.block_start);
				errors++;
			end
			if (a.units_in_use !== e.units_in_use) begin
				$error("units_in_use: expected %0d, actual %0d", e.units_in_use,
					a.units_in_use);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ffra_req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ffra_rsp_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [16:0] cfg_data = '0;

	alloc_scoreboard sb = new();
	bit no_idle = 1'b0;
	int rsp_hold = 0;
	int req_total = 0;
	int cfg_total = 0;

	first_fit_range_allocator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		#4000000;
		$display("first_fit_range_allocator_core regression: fail");
		$finish;
	end

	// response side: check each transfer, then stall a random number of cycles
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sb.check_response(out_data);
			rsp_hold = no_idle ? 0 : $urandom_range(0, 8);
		end else if (rsp_hold > 0) begin
			rsp_hold--;
		end
		out_stall <= (rsp_hold > 0);
	end

	// one request transfer after a random gap; valid stays high for a back-to-back item
	task automatic send_request(input ffra_req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
		req_total++;
	endtask

	task automatic send(input logic [1:0] k, input int off, input int size);
		ffra_req_t r;
		r.kind = k;
		r.offset = off[15:0];
		r.req_size = size[16:0];
		send_request(r);
	endtask

	// let all responses arrive, then idle before returning
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_pool(input logic [16:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.pool = v;
		cfg_total++;
	endtask

	// random request shaped by the current table
	function automatic ffra_req_t pick_request();
		ffra_req_t r;
		int p;
		int e;
		int len;
		int size;
		len = sb.pool_len();
		p = $urandom_range(0, 99);
		if (p < 2) r.kind = KIND_UNDEF;
		else if (p < 45 && !(sb.count >= 12 && p > 30)) r.kind = KIND_ALLOC;
		else if (p < 72) r.kind = KIND_FREE;
		else r.kind = KIND_REALLOC;
		if (sb.count > 0 && $urandom_range(0, 9) != 0) begin
			e = $urandom_range(0, sb.count - 1);
			r.offset = 16'(sb.lo[e] + $urandom_range(0, sb.hi[e] - sb.lo[e]));
		end else begin
			r.offset = 16'($urandom);
		end
		p = $urandom_range(0, 99);
		if (p < 2) size = 0;
		else if (p < 4) size = 65536;
		else if (p < 7) size = $urandom_range(0, 131071);
		else if (p < 17) size = $urandom_range(1, len);
		else size = $urandom_range(1, len / 12 + 1);
		r.req_size = size[16:0];
		return r;
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
			send_request(pick_request());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full pool, empty table, bad offsets, zero size, unknown kind
		send(KIND_ALLOC, 0, 65536);
		send(KIND_ALLOC, 0, 1);
		send(KIND_FREE, 65535, 0);
		send(KIND_FREE, 0, 0);
		send(KIND_REALLOC, 0, 5);
		send(KIND_ALLOC, 0, 0);
		send(KIND_UNDEF, 0, 1);
		// fill the table, then one more alloc for table full
		for (int i = 0; i < MAX_ENTRIES; i++) send(KIND_ALLOC, 0, 10);
		send(KIND_ALLOC, 0, 1);
		// exact fit before first entry, shrink, grow in place at the end, move
		send(KIND_FREE, 3, 0);
		send(KIND_ALLOC, 0, 10);
		send(KIND_REALLOC, 25, 4);
		send(KIND_REALLOC, 155, 1000);
		send(KIND_REALLOC, 0, 20);
		drain();

		// random phases over several pool sizes, including a shrink below live entries
		write_pool(17'd65536);
		random_phase(350);
		drain();
		write_pool(17'd100);
		random_phase(250);
		drain();
		write_pool(17'd1);
		random_phase(150);
		drain();
		write_pool(17'd65535);
		random_phase(350);
		drain();
		write_pool(17'd300);
		random_phase(250);
		drain();
		write_pool(17'd65536);
		random_phase(200);
		drain();

		if (sb.expected_q.size() != 0) begin
			$error("%0d responses never arrived", sb.expected_q.size());
			sb.errors++;
		end
		$display("%0d requests, %0d responses checked, %0d pool size writes",
			req_total, sb.checked, cfg_total);
		if (sb.errors == 0)
			$display("first_fit_range_allocator_core regression: pass");
		else
			$display("first_fit_range_allocator_core regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ffra_pkg.sv
rtl/core/ffra_cell.sv
rtl/core/first_fit_range_allocator_core.sv
test/first_fit_range_allocator_core_test.sv
